// ===== src/hopf_cpg_trot_generator_assert.svh =====
// Assertion macros shared by the gait generator.
`ifndef HOPF_CPG_TROT_GENERATOR_ASSERT_SVH
`define HOPF_CPG_TROT_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define HCPG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define HCPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hcpg_pkg.sv =====
`timescale 1ns / 1ps

package hcpg_pkg;

    localparam int NUM_LEGS = 4;
    localparam int SINE_TABLE_DEPTH_DEFAULT = 256;
    localparam int LEG_W = 2;
    localparam int PROD_W = 52;

    localparam logic [14:0] STEP_AMPLITUDE_RST = 15'd2621;
    localparam logic [14:0] STANCE_LIFT_RST = 15'd328;
    localparam logic [14:0] SWING_LIFT_RST = 15'd3277;
    localparam logic signed [15:0] BODY_HEIGHT_RST = 16'sd0;
    localparam logic [15:0] RADIUS_RATE_RST = 16'd13107;
    localparam logic [14:0] COUPLING_GAIN_RST = 15'd4172;
    localparam logic [13:0] STANCE_INCREMENT_RST = 14'd1049;
    localparam logic [13:0] SWING_INCREMENT_RST = 14'd1573;
    localparam logic [15:0] RADIUS_RST = 16'd14746;

    // register indexes on the configuration port
    localparam logic [2:0] REG_STEP_AMPLITUDE = 3'd0;
    localparam logic [2:0] REG_STANCE_LIFT = 3'd1;
    localparam logic [2:0] REG_SWING_LIFT = 3'd2;
    localparam logic [2:0] REG_BODY_HEIGHT = 3'd3;
    localparam logic [2:0] REG_RADIUS_RATE = 3'd4;
    localparam logic [2:0] REG_COUPLING_GAIN = 3'd5;
    localparam logic [2:0] REG_STANCE_INCREMENT = 3'd6;
    localparam logic [2:0] REG_SWING_INCREMENT = 3'd7;

    localparam logic [15:0] TROT_TARGET [NUM_LEGS] = '{16'd0, 16'd32768, 16'd32768, 16'd0};
    localparam logic [15:0] LEG_OFFSET [NUM_LEGS] =
        '{16'd1043, 16'd64493, 16'd1043, 16'd64493};
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    typedef logic [3:0] op_t;
    localparam op_t OP_NONE = 4'd0;
    localparam op_t OP_RAD1 = 4'd1;
    localparam op_t OP_RAD2 = 4'd2;
    localparam op_t OP_CPL = 4'd3;
    localparam op_t OP_GAIN = 4'd4;
    localparam op_t OP_COMMIT = 4'd5;
    localparam op_t OP_XA = 4'd6;
    localparam op_t OP_XB = 4'd7;
    localparam op_t OP_ZA = 4'd8;
    localparam op_t OP_ZB = 4'd9;
    localparam op_t OP_LOAD = 4'd10;

    typedef struct packed {
        op_t             op;
        logic [LEG_W-1:0] leg;
        logic [LEG_W-1:0] peer;
    } hcpg_cmd_t;

    // Q14 sine of a grid angle, polynomial on the folded quarter wave
    function automatic int sine_value(input int q);
        int z;
        int u;
        int u2;
        int t;
        if (q < 16384) z = q;
        else if (q < 49152) z = 32768 - q;
        else z = q - 65536;
        u = (z < 0) ? -z : z;
        u2 = (u * u) >>> 14;
        t = (1160 * u2) >>> 14;
        t = (u2 * (10513 - t)) >>> 14;
        t = (u * (25736 - t)) >>> 14;
        return (z < 0) ? -t : t;
    endfunction

    function automatic logic sine_positive(input logic [15:0] a);
        return (a != 16'd0) && !a[15];
    endfunction

    function automatic logic signed [PROD_W-1:0] round_shr(
        input logic signed [PROD_W-1:0] v,
        input int unsigned sh
    );
        logic signed [PROD_W-1:0] w;
        w = v + (PROD_W'(1) <<< (sh - 1));
        return w >>> sh;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        if (v > PROD_W'(32767)) return 16'sh7fff;
        if (v < -PROD_W'(32768)) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== src/hcpg_gait_if.sv =====
`timescale 1ns / 1ps

interface hcpg_gait_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// ===== src/hcpg_feet_if.sv =====
`timescale 1ns / 1ps

interface hcpg_feet_if;
    logic valid;
    logic ready;
    logic signed [15:0] front_right_x;
    logic signed [15:0] front_right_z;
    logic signed [15:0] front_left_x;
    logic signed [15:0] front_left_z;
    logic signed [15:0] back_right_x;
    logic signed [15:0] back_right_z;
    logic signed [15:0] back_left_x;
    logic signed [15:0] back_left_z;

    modport source (
        output valid,
        output front_right_x, output front_right_z,
        output front_left_x, output front_left_z,
        output back_right_x, output back_right_z,
        output back_left_x, output back_left_z,
        input ready
    );
    modport sink (
        input valid,
        input front_right_x, input front_right_z,
        input front_left_x, input front_left_z,
        input back_right_x, input back_right_z,
        input back_left_x, input back_left_z,
        output ready
    );
endinterface

// ===== src/hcpg_ctrl.sv =====
`timescale 1ns / 1ps

module hcpg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gait_valid,
    input  logic               gait_tick,
    output logic               gait_ready,
    output logic               feet_valid,
    input  logic               feet_ready,
    output hcpg_pkg::hcpg_cmd_t cmd
);
    import hcpg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RAD1 = 4'd1;
    localparam logic [3:0] S_RAD2 = 4'd2;
    localparam logic [3:0] S_CPL = 4'd3;
    localparam logic [3:0] S_GAIN = 4'd4;
    localparam logic [3:0] S_COMMIT = 4'd5;
    localparam logic [3:0] S_XA = 4'd6;
    localparam logic [3:0] S_XB = 4'd7;
    localparam logic [3:0] S_ZA = 4'd8;
    localparam logic [3:0] S_ZB = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam logic [LEG_W-1:0] LAST_LEG = LEG_W'(NUM_LEGS - 1);
    localparam logic [LEG_W-1:0] LEG_ONE = LEG_W'(1);

    logic [3:0] state_reg, state_next;
    logic [LEG_W-1:0] leg_reg, leg_next;
    logic [LEG_W-1:0] peer_reg, peer_next;
    logic valid_reg, valid_next;
    logic load;

    assign gait_ready = (state_reg == S_IDLE);
    assign feet_valid = valid_reg;
    assign load = (state_reg == S_DONE) && (!valid_reg || feet_ready);

    always_comb
    begin
        state_next = state_reg;
        leg_next = leg_reg;
        peer_next = peer_reg;
        cmd.leg = leg_reg;
        cmd.peer = peer_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                leg_next = '0;
                peer_next = '0;
                if (gait_valid)
                begin
                    state_next = gait_tick ? S_RAD1 : S_XA;
                end
            end
            S_RAD1:
            begin
                cmd.op = OP_RAD1;
                state_next = S_RAD2;
            end
            S_RAD2:
            begin
                cmd.op = OP_RAD2;
                peer_next = '0;
                state_next = S_CPL;
            end
            S_CPL:
            begin
                cmd.op = OP_CPL;
                peer_next = peer_reg + LEG_ONE;
                if (peer_reg == LAST_LEG)
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.op = OP_GAIN;
                leg_next = leg_reg + LEG_ONE;
                state_next = (leg_reg == LAST_LEG) ? S_COMMIT : S_RAD1;
            end
            S_COMMIT:
            begin
                cmd.op = OP_COMMIT;
                leg_next = '0;
                state_next = S_XA;
            end
            S_XA:
            begin
                cmd.op = OP_XA;
                state_next = S_XB;
            end
            S_XB:
            begin
                cmd.op = OP_XB;
                state_next = S_ZA;
            end
            S_ZA:
            begin
                cmd.op = OP_ZA;
                state_next = S_ZB;
            end
            S_ZB:
            begin
                cmd.op = OP_ZB;
                leg_next = leg_reg + LEG_ONE;
                state_next = (leg_reg == LAST_LEG) ? S_DONE : S_XA;
            end
            S_DONE:
            begin
                if (load)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (feet_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            leg_reg <= '0;
            peer_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            leg_reg <= leg_next;
            peer_reg <= peer_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== src/hcpg_datapath.sv =====
`timescale 1ns / 1ps

module hcpg_datapath #(
    parameter int SINE_TABLE_DEPTH = hcpg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hcpg_pkg::hcpg_cmd_t cmd,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic signed [15:0]  pos_x [hcpg_pkg::NUM_LEGS],
    output logic signed [15:0]  pos_z [hcpg_pkg::NUM_LEGS]
);
    import hcpg_pkg::*;

    localparam int LUT_BITS = $clog2(SINE_TABLE_DEPTH);

    logic [14:0] step_amplitude_reg, stance_lift_reg, swing_lift_reg, coupling_gain_reg;
    logic signed [15:0] body_height_reg;
    logic [15:0] radius_rate_reg;
    logic [13:0] stance_increment_reg, swing_increment_reg;

    logic [15:0] radius_reg [NUM_LEGS];
    logic [15:0] phase_reg [NUM_LEGS];
    logic [15:0] nr_reg [NUM_LEGS];
    logic [15:0] np_reg [NUM_LEGS];
    logic signed [15:0] x_reg [NUM_LEGS];
    logic signed [15:0] z_reg [NUM_LEGS];
    logic signed [15:0] out_x_reg [NUM_LEGS];
    logic signed [15:0] out_z_reg [NUM_LEGS];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [18:0] acc_reg;

    logic signed [15:0] sine_lut [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_lut
        assign sine_lut[g] = 16'(sine_value(int'(g) << (16 - LUT_BITS)));
    end

    logic [15:0] r_cur, ph_cur, ph_peer, arg, p_leg, p_cos;
    logic signed [15:0] s_arg, s_sin, s_cos;
    logic signed [18:0] term;
    logic [14:0] lift;
    logic [13:0] inc;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] r_sum;
    logic signed [PROD_W-1:0] dc;
    logic [15:0] r_new;

    always_comb
    begin
        r_cur = radius_reg[cmd.leg];
        ph_cur = phase_reg[cmd.leg];
        ph_peer = phase_reg[cmd.peer];
        arg = ph_peer - ph_cur - (TROT_TARGET[cmd.peer] - TROT_TARGET[cmd.leg]);
        s_arg = sine_lut[arg[15 -: LUT_BITS]];
        // diagonal pairs count twice, the leg itself not at all
        if (cmd.peer == cmd.leg)
            term = '0;
        else if (({1'b0, cmd.leg} + {1'b0, cmd.peer}) == 3'd3)
            term = {{2{s_arg[15]}}, s_arg, 1'b0};
        else
            term = {{3{s_arg[15]}}, s_arg};
        p_leg = ph_cur + LEG_OFFSET[cmd.leg];
        p_cos = p_leg + QUARTER_TURN;
        s_sin = sine_lut[p_leg[15 -: LUT_BITS]];
        s_cos = sine_lut[p_cos[15 -: LUT_BITS]];
        lift = sine_positive(p_leg) ? swing_lift_reg : stance_lift_reg;
        inc = sine_positive(ph_cur) ? swing_increment_reg : stance_increment_reg;
    end

    // shared multiplier, one product per cycle
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_RAD1:
            begin
                mul_a = 34'(17'sd16384 - signed'({1'b0, r_cur}));
                mul_b = 18'(signed'({1'b0, r_cur}));
            end
            OP_RAD2:
            begin
                mul_a = prod_reg[33:0];
                mul_b = 18'(signed'({1'b0, radius_rate_reg}));
            end
            OP_GAIN:
            begin
                mul_a = 34'(acc_reg);
                mul_b = 18'(signed'({1'b0, coupling_gain_reg}));
            end
            OP_XA:
            begin
                mul_a = 34'(signed'({1'b0, step_amplitude_reg}));
                mul_b = 18'(signed'({1'b0, r_cur}));
            end
            OP_XB:
            begin
                mul_a = prod_reg[33:0];
                mul_b = 18'(s_cos);
            end
            OP_ZA:
            begin
                mul_a = 34'(signed'({1'b0, lift}));
                mul_b = 18'(signed'({1'b0, r_cur}));
            end
            OP_ZB:
            begin
                mul_a = prod_reg[33:0];
                mul_b = 18'(s_sin);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
        r_sum = round_shr(prod, 30) + PROD_W'(signed'({1'b0, r_cur}));
        if (r_sum < 0)
            r_new = 16'd0;
        else if (r_sum > PROD_W'(65535))
            r_new = 16'hffff;
        else
            r_new = r_sum[15:0];
        dc = round_shr(prod, 15);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_RAD1:
            begin
                prod_reg <= prod;
                acc_reg <= '0;
            end
            OP_RAD2:
            begin
                nr_reg[cmd.leg] <= r_new;
            end
            OP_CPL:
            begin
                acc_reg <= acc_reg + term;
            end
            OP_GAIN:
            begin
                np_reg[cmd.leg] <= ph_cur + 16'(inc) + dc[15:0];
            end
            OP_XA, OP_ZA:
            begin
                prod_reg <= prod;
            end
            OP_XB:
            begin
                x_reg[cmd.leg] <= sat16(round_shr(-prod, 28));
            end
            OP_ZB:
            begin
                z_reg[cmd.leg] <= sat16(round_shr(prod, 28) + PROD_W'(body_height_reg));
            end
            OP_LOAD:
            begin
                out_x_reg <= x_reg;
                out_z_reg <= z_reg;
            end
            default:
            begin
            end
        endcase
    end

    // oscillator state: all legs move together from the old state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEGS; i++)
            begin
                radius_reg[i] <= RADIUS_RST;
                phase_reg[i] <= TROT_TARGET[i];
            end
        end
        else if (cmd.op == OP_COMMIT)
        begin
            radius_reg <= nr_reg;
            phase_reg <= np_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_amplitude_reg <= STEP_AMPLITUDE_RST;
            stance_lift_reg <= STANCE_LIFT_RST;
            swing_lift_reg <= SWING_LIFT_RST;
            body_height_reg <= BODY_HEIGHT_RST;
            radius_rate_reg <= RADIUS_RATE_RST;
            coupling_gain_reg <= COUPLING_GAIN_RST;
            stance_increment_reg <= STANCE_INCREMENT_RST;
            swing_increment_reg <= SWING_INCREMENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_AMPLITUDE: step_amplitude_reg <= cfg_data[14:0];
                REG_STANCE_LIFT: stance_lift_reg <= cfg_data[14:0];
                REG_SWING_LIFT: swing_lift_reg <= cfg_data[14:0];
                REG_BODY_HEIGHT: body_height_reg <= cfg_data;
                REG_RADIUS_RATE: radius_rate_reg <= cfg_data;
                REG_COUPLING_GAIN: coupling_gain_reg <= cfg_data[14:0];
                REG_STANCE_INCREMENT: stance_increment_reg <= cfg_data[13:0];
                REG_SWING_INCREMENT: swing_increment_reg <= cfg_data[13:0];
                default:
                begin
                end
            endcase
        end
    end

    assign pos_x = out_x_reg;
    assign pos_z = out_z_reg;

endmodule

// ===== src/hopf_cpg_trot_generator.sv =====
`timescale 1ns / 1ps
// channel | role   | handshake    | payload
// gait    | sink   | valid/ready  | tick (1 = step oscillators, 0 = re-emit)
// feet    | source | valid/ready  | x and z of all four feet, s16 each
//
// A transaction with tick = 1 runs, for each of the four legs in turn, a radius
// step, a coupling sum over all peers and a gain step, then one commit, then foot placement
// for the four legs; tick = 0 skips the oscillator step and goes straight to foot placement.
// A single shared multiplier forms every product, one product per cycle.
// Reset loads radius 0.9 and the trot phase pattern and restores register defaults.
// A finished result sits in the output register; the next transaction is accepted
// while it waits, and the block stalls only when a second result is ready first.

module hopf_cpg_trot_generator #(
    parameter int SINE_TABLE_DEPTH = hcpg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    hcpg_gait_if.sink   gait,
    hcpg_feet_if.source feet,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hcpg_pkg::*;

    `include "hopf_cpg_trot_generator_assert.svh"

    hcpg_cmd_t cmd;
    logic signed [15:0] pos_x [NUM_LEGS];
    logic signed [15:0] pos_z [NUM_LEGS];

    // sequencer: walks legs and steps, owns both handshakes
    hcpg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .gait_valid (gait.valid),
        .gait_tick  (gait.tick),
        .gait_ready (gait.ready),
        .feet_valid (feet.valid),
        .feet_ready (feet.ready),
        .cmd        (cmd)
    );

    // oscillator state, configuration, multiplier and result registers
    hcpg_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_z     (pos_z)
    );

    // leg order: front right, front left, back right, back left
    assign feet.front_right_x = pos_x[0];
    assign feet.front_right_z = pos_z[0];
    assign feet.front_left_x = pos_x[1];
    assign feet.front_left_z = pos_z[1];
    assign feet.back_right_x = pos_x[2];
    assign feet.back_right_z = pos_z[2];
    assign feet.back_left_x = pos_x[3];
    assign feet.back_left_z = pos_z[3];

    // busy right after an accepted transaction
    `HCPG_ASSERT_NEXT(a_busy_after_accept, gait.valid && gait.ready, !gait.ready, "not busy")
    // never overwrite a result that has not been taken
    `HCPG_ASSERT_IMPL(a_load_free, cmd.op == OP_LOAD, !feet.valid || feet.ready, "overwrite")
    // foot placement follows the oscillator commit
    `HCPG_ASSERT_NEXT(a_commit_then_place, cmd.op == OP_COMMIT, cmd.op == OP_XA, "bad order")

endmodule
